FILE: hdl/window_median_filter_macros.svh
// Assertion macros used by the filter top module.
`ifndef WINDOW_MEDIAN_FILTER_MACROS_SVH
`define WINDOW_MEDIAN_FILTER_MACROS_SVH

`ifndef SYNTHESIS
`define WMF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("window_median_filter: check failed");
`define WMF_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("window_median_filter: forbidden condition");
`else
`define WMF_ASSERT(lbl, clk, rstn, prop)
`define WMF_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

FILE: hdl/wmf_pkg.sv
package wmf_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_KERNEL_DEF = 7;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int NUM_CH     = 3;

  localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic [2:0]  KERNEL_SIZE_RST  = 3'd3;
  localparam logic        COLOR_MODE_RST   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_KERNEL_SIZE,
    REG_COLOR_MODE
  } reg_idx_e;

  typedef struct packed {
    logic [11:0] row;
    logic [10:0] col;
    logic        last;
  } side_t;

endpackage

FILE: hdl/wmf_intf.sv
interface wmf_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_ch0;
  logic [7:0] pixel_ch1;
  logic [7:0] pixel_ch2;
  logic       frame_start;
  modport source (output valid, pixel_ch0, pixel_ch1, pixel_ch2, frame_start, input ready);
  modport sink (input valid, pixel_ch0, pixel_ch1, pixel_ch2, frame_start, output ready);
endinterface

interface wmf_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  median_ch0;
  logic [7:0]  median_ch1;
  logic [7:0]  median_ch2;
  logic [11:0] center_row;
  logic [10:0] center_col;
  logic        last_of_frame;
  modport source (output valid, median_ch0, median_ch1, median_ch2, center_row, center_col,
                  last_of_frame, input ready);
  modport sink (input valid, median_ch0, median_ch1, median_ch2, center_row, center_col,
                last_of_frame, output ready);
endinterface

interface wmf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [wmf_pkg::CFG_IDX_W-1:0]   index;
  logic [wmf_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/wmf_ram.sv
module wmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/wmf_cell.sv
module wmf_cell #(
  parameter int N   = 49,
  parameter int RW  = 6,
  parameter int BIT = 7
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  wmf_pkg::side_t                             side_i,
  input  logic [wmf_pkg::NUM_CH-1:0][N-1:0][7:0]     vals_i,
  input  logic [wmf_pkg::NUM_CH-1:0][N-1:0]          mask_i,
  input  logic [wmf_pkg::NUM_CH-1:0][RW-1:0]         rank_i,
  input  logic [wmf_pkg::NUM_CH-1:0][7:0]            res_i,
  output logic                                       valid_o,
  output wmf_pkg::side_t                             side_o,
  output logic [wmf_pkg::NUM_CH-1:0][N-1:0][7:0]     vals_o,
  output logic [wmf_pkg::NUM_CH-1:0][N-1:0]          mask_o,
  output logic [wmf_pkg::NUM_CH-1:0][RW-1:0]         rank_o,
  output logic [wmf_pkg::NUM_CH-1:0][7:0]            res_o
);

  localparam int CNW = $clog2(N + 1);

  logic                                   valid_q;
  wmf_pkg::side_t                         side_q;
  logic [wmf_pkg::NUM_CH-1:0][N-1:0][7:0] vals_q;
  logic [wmf_pkg::NUM_CH-1:0][N-1:0]      mask_q, mask_d;
  logic [wmf_pkg::NUM_CH-1:0][RW-1:0]     rank_q, rank_d;
  logic [wmf_pkg::NUM_CH-1:0][7:0]        res_q, res_d;

  always_comb begin
    logic [CNW-1:0] zeros;
    logic [N-1:0]   ones;
    mask_d = mask_i;
    rank_d = rank_i;
    res_d  = res_i;
    for (int ch = 0; ch < wmf_pkg::NUM_CH; ch++) begin
      zeros = '0;
      for (int i = 0; i < N; i++) begin
        ones[i] = vals_i[ch][i][BIT];
        zeros   = zeros + CNW'(mask_i[ch][i] & ~vals_i[ch][i][BIT]);
      end
      if (CNW'(rank_i[ch]) < zeros) begin
        res_d[ch][BIT] = 1'b0;
        mask_d[ch]     = mask_i[ch] & ~ones;
      end else begin
        res_d[ch][BIT] = 1'b1;
        mask_d[ch]     = mask_i[ch] & ones;
        rank_d[ch]     = rank_i[ch] - RW'(zeros);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      vals_q <= vals_i;
      mask_q <= mask_d;
      rank_q <= rank_d;
      res_q  <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign vals_o  = vals_q;
  assign mask_o  = mask_q;
  assign rank_o  = rank_q;
  assign res_o   = res_q;

endmodule

FILE: hdl/window_median_filter.sv
// Channel   Dir  Moves per transaction
// pix_i     in   one pixel: three channel bytes, frame start mark
// res_o     out  one median result: three medians, centre row/col, last mark
// cfg_i     in   one register write: index, data
// Accepts one pixel per cycle while res_o is not stalled.
// A pixel passes the line store read, the window shift and eight bit cells on its way to a result.
// Reset clears the registers to their defaults and the position counters to zero.
// A stalled result holds the whole pipeline; pix_i ready drops with it.
`include "window_median_filter_macros.svh"

module window_median_filter #(
  parameter int MAX_WIDTH  = wmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = wmf_pkg::MAX_KERNEL_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wmf_pix_if.sink   pix_i,
  wmf_res_if.source res_o,
  wmf_cfg_if.sink   cfg_i
);

  localparam int S   = MAX_KERNEL - 1;
  localparam int SW  = $clog2(S);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int N   = MAX_KERNEL * MAX_KERNEL;
  localparam int RW  = $clog2(N);
  localparam int KW  = $clog2(MAX_KERNEL + 1);
  localparam int NCH = wmf_pkg::NUM_CH;

  logic [11:0] fw_q, fh_q;
  logic [2:0]  ks_q;
  logic        cm_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= wmf_pkg::FRAME_WIDTH_RST;
      fh_q <= wmf_pkg::FRAME_HEIGHT_RST;
      ks_q <= wmf_pkg::KERNEL_SIZE_RST;
      cm_q <= wmf_pkg::COLOR_MODE_RST;
    end else if (cfg_i.valid) begin
      unique case (wmf_pkg::reg_idx_e'(cfg_i.index))
        wmf_pkg::REG_FRAME_WIDTH:  fw_q <= cfg_i.data[11:0];
        wmf_pkg::REG_FRAME_HEIGHT: fh_q <= cfg_i.data[11:0];
        wmf_pkg::REG_KERNEL_SIZE:  ks_q <= cfg_i.data[2:0];
        wmf_pkg::REG_COLOR_MODE:   cm_q <= cfg_i.data[0];
      endcase
    end
  end

  logic [CW:0]   w_eff;
  logic [11:0]   h_eff;
  logic [KW-1:0] k_eff, km1, off;

  always_comb begin
    if (fw_q == '0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(fw_q);
    end
    h_eff = (fh_q == '0) ? 12'd1 : fh_q;
    if (ks_q == '0) begin
      k_eff = KW'(1);
    end else if (32'(ks_q) > 32'(MAX_KERNEL)) begin
      k_eff = KW'(MAX_KERNEL);
    end else begin
      k_eff = KW'(ks_q);
    end
    if (!k_eff[0]) begin
      k_eff = k_eff - KW'(1);
    end
    km1 = k_eff - KW'(1);
    off = k_eff >> 1;
  end

  logic en, accept;
  logic fin_v;

  assign en          = !fin_v || res_o.ready;
  assign pix_i.ready = en;
  assign accept      = pix_i.valid && en;

  logic [CW-1:0] col_q, col_d, c0;
  logic [11:0]   row_q, row_d, r0;
  logic [SW-1:0] slot_q, slot_d, sl0;
  logic [CW:0]   c_nx;
  logic [23:0]   pix0;
  logic          emit0;
  wmf_pkg::side_t side0;

  always_comb begin
    if (pix_i.frame_start) begin
      c0  = '0;
      r0  = '0;
      sl0 = '0;
    end else begin
      c0  = col_q;
      r0  = row_q;
      sl0 = slot_q;
    end
    if ({1'b0, c0} >= w_eff) begin
      c0  = '0;
      r0  = r0 + 12'd1;
      sl0 = (sl0 == SW'(S - 1)) ? '0 : sl0 + SW'(1);
    end
    if (r0 >= h_eff) begin
      r0  = '0;
      sl0 = '0;
    end
    c_nx   = {1'b0, c0} + (CW+1)'(1);
    col_d  = c_nx[CW-1:0];
    row_d  = r0;
    slot_d = sl0;
    if (c_nx >= w_eff) begin
      col_d  = '0;
      row_d  = r0 + 12'd1;
      slot_d = (sl0 == SW'(S - 1)) ? '0 : sl0 + SW'(1);
      if (r0 + 12'd1 >= h_eff) begin
        row_d  = '0;
        slot_d = '0;
      end
    end
    pix0 = {8'h00, 8'h00, pix_i.pixel_ch0};
    if (cm_q) begin
      pix0 = {pix_i.pixel_ch2, pix_i.pixel_ch1, pix_i.pixel_ch0};
    end
    emit0      = (r0 >= 12'(km1)) && ({1'b0, c0} >= (CW+1)'(km1));
    side0.row  = r0 - 12'(off);
    side0.col  = 11'(c0 - CW'(off));
    side0.last = (r0 == h_eff - 12'd1) && ({1'b0, c0} == w_eff - (CW+1)'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (accept) begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

  logic [23:0] rd [S];

  for (genvar s = 0; s < S; s++) begin : g_line
    wmf_ram #(
      .WIDTH(24),
      .DEPTH(MAX_WIDTH)
    ) u_line (
      .clk_i  (clk_i),
      .we_i   (accept && (sl0 == SW'(s))),
      .waddr_i(c0),
      .wdata_i(pix0),
      .re_i   (accept),
      .raddr_i(c0),
      .rdata_o(rd[s])
    );
  end

  logic           p0_v_q, p0_emit_q;
  logic [23:0]    p0_pix_q;
  logic [SW-1:0]  p0_slot_q;
  wmf_pkg::side_t p0_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q <= 1'b0;
    end else if (en) begin
      p0_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p0_emit_q <= emit0;
      p0_pix_q  <= pix0;
      p0_slot_q <= sl0;
      p0_side_q <= side0;
    end
  end

  logic [23:0] col_new [MAX_KERNEL];

  always_comb begin
    logic [SW:0] sum;
    col_new[0] = p0_pix_q;
    for (int d = 1; d < MAX_KERNEL; d++) begin
      sum = {1'b0, p0_slot_q} + (SW+1)'(S - d);
      if (sum >= (SW+1)'(S)) begin
        sum = sum - (SW+1)'(S);
      end
      col_new[d] = rd[SW'(sum)];
    end
  end

  logic [23:0]    win_q [MAX_KERNEL][MAX_KERNEL];
  logic           w_v_q;
  wmf_pkg::side_t w_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_v_q <= 1'b0;
    end else if (en) begin
      w_v_q <= p0_v_q && p0_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && p0_v_q) begin
      w_side_q <= p0_side_q;
      for (int d = 0; d < MAX_KERNEL; d++) begin
        win_q[d][0] <= col_new[d];
        for (int j = 1; j < MAX_KERNEL; j++) begin
          win_q[d][j] <= win_q[d][j-1];
        end
      end
    end
  end

  logic                          cv    [8];
  wmf_pkg::side_t                cside [8];
  logic [NCH-1:0][N-1:0][7:0]    cvals [8];
  logic [NCH-1:0][N-1:0]         cmask [8];
  logic [NCH-1:0][RW-1:0]        crank [8];
  logic [NCH-1:0][7:0]           cres  [8];
  logic [2*KW-1:0]               kk;
  wmf_pkg::side_t                fin_side;
  logic [NCH-1:0][7:0]           fin_res;

  always_comb begin
    kk       = (2*KW)'(k_eff) * (2*KW)'(k_eff);
    cv[0]    = w_v_q;
    cside[0] = w_side_q;
    cres[0]  = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      crank[0][ch] = RW'(kk >> 1);
      for (int d = 0; d < MAX_KERNEL; d++) begin
        for (int j = 0; j < MAX_KERNEL; j++) begin
          cvals[0][ch][d*MAX_KERNEL+j] = win_q[d][j][ch*8 +: 8];
          cmask[0][ch][d*MAX_KERNEL+j] = (KW'(d) < k_eff) && (KW'(j) < k_eff);
        end
      end
    end
  end

  for (genvar b = 0; b < 8; b++) begin : g_cell
    if (b < 7) begin : g_mid
      wmf_cell #(.N(N), .RW(RW), .BIT(7 - b)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .valid_i(cv[b]),
        .side_i (cside[b]),
        .vals_i (cvals[b]),
        .mask_i (cmask[b]),
        .rank_i (crank[b]),
        .res_i  (cres[b]),
        .valid_o(cv[b+1]),
        .side_o (cside[b+1]),
        .vals_o (cvals[b+1]),
        .mask_o (cmask[b+1]),
        .rank_o (crank[b+1]),
        .res_o  (cres[b+1])
      );
    end else begin : g_end
      wmf_cell #(.N(N), .RW(RW), .BIT(7 - b)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .valid_i(cv[b]),
        .side_i (cside[b]),
        .vals_i (cvals[b]),
        .mask_i (cmask[b]),
        .rank_i (crank[b]),
        .res_i  (cres[b]),
        .valid_o(fin_v),
        .side_o (fin_side),
        .vals_o (),
        .mask_o (),
        .rank_o (),
        .res_o  (fin_res)
      );
    end
  end

  assign res_o.valid         = fin_v;
  assign res_o.median_ch0    = fin_res[0];
  assign res_o.median_ch1    = cm_q ? fin_res[1] : 8'h00;
  assign res_o.median_ch2    = cm_q ? fin_res[2] : 8'h00;
  assign res_o.center_row    = fin_side.row;
  assign res_o.center_col    = fin_side.col;
  assign res_o.last_of_frame = fin_side.last;

  `WMF_ASSERT_NEVER(a_slot_range, clk_i, rst_ni, ({1'b0, slot_q} >= (SW+1)'(S)))
  `WMF_ASSERT_NEVER(a_col_range, clk_i, rst_ni, (32'(col_q) >= 32'(MAX_WIDTH)))
  `WMF_ASSERT(a_frame_restart, clk_i, rst_ni,
              (accept && pix_i.frame_start) |=> (p0_slot_q == '0 && p0_side_q.last == ((h_eff == 12'd1) && (w_eff == (CW+1)'(1))) || p0_side_q.row == 12'(-$signed({1'b0, $past(off)}))))

endmodule
